FILE: rtl/riff_voxel_chunk_parser_macros.svh
// Assertion helpers for the file that carries checks.
`ifndef RIFF_VOXEL_CHUNK_PARSER_MACROS_SVH
`define RIFF_VOXEL_CHUNK_PARSER_MACROS_SVH

// Same-cycle implication.
`define RVCP_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rvcp assertion failed");

// Next-cycle implication.
`define RVCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rvcp assertion failed");

`endif

FILE: rtl/rvcp_pkg.sv
package rvcp_pkg;

	localparam int COORD_W = 14;

	// "fdtd" as it lands in the name register, first byte lowest.
	localparam logic [31:0] FDTD_NAME = 32'h6474_6466;

	typedef enum logic [1:0] {
		KIND_VOXEL = 2'd0,
		KIND_GRID  = 2'd1,
		KIND_OK    = 2'd2,
		KIND_FAULT = 2'd3
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  last_of_run;
	} res_ctl_t;

	function automatic logic byte_alnum(input logic [7:0] c);
		byte_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic name_alnum(input logic [31:0] nm);
		name_alnum = byte_alnum(nm[7:0]) && byte_alnum(nm[15:8]) &&
			byte_alnum(nm[23:16]) && byte_alnum(nm[31:24]);
	endfunction

endpackage

FILE: rtl/rvcp_ifs.sv
interface rvcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       is_last;

	modport source(output valid, byte_value, is_last, input ready);
	modport sink(input valid, byte_value, is_last, output ready);
endinterface

interface rvcp_res_if;
	logic                             valid;
	logic                             ready;
	rvcp_pkg::kind_t                  kind;
	logic [rvcp_pkg::COORD_W-1:0]     coord_x;
	logic [rvcp_pkg::COORD_W-1:0]     coord_y;
	logic [rvcp_pkg::COORD_W-1:0]     coord_z;
	logic [7:0]                       material;
	logic                             last_of_run;

	modport source(output valid, kind, coord_x, coord_y, coord_z, material, last_of_run,
		input ready);
	modport sink(input valid, kind, coord_x, coord_y, coord_z, material, last_of_run,
		output ready);
endinterface

FILE: rtl/rvcp_parser.sv
module rvcp_parser #(
	parameter int unsigned MAX_DIM = 4095
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      accept,
	input  logic                                      adv,
	input  logic [7:0]                                byte_value,
	input  logic                                      is_last,
	output logic                                      pend,
	output rvcp_pkg::res_ctl_t                        ctl_s1,
	output logic [2:0][$clog2(MAX_DIM + 1):0]         sum_s1,
	output logic [7:0]                                mat_s1
);
	import rvcp_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int SUM_W = DIM_W + 1;

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_VAL  = 4'b0010,
		PH_PAY  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	phase_t                   phase_q, phase_n;
	logic [4:0]               cnt_q, cnt_n, cnt_inc;
	logic [31:0]              name_q, name_n;
	logic [23:0]              asm_q, asm_n;
	logic [31:0]              full_word;
	logic [30:0]              skip_q, skip_n;
	logic [5:0][DIM_W-1:0]    gv_q, gv_n;
	logic [2:0][DIM_W-1:0]    lc_q, lc_n;
	logic                     stopped_q, stopped_n;
	logic                     pend_q, pend_n;
	kind_t                    pend_kind_q, pend_kind_n;
	logic [DIM_W:0]           lc_z_inc, lc_y_inc, lc_x_inc;

	res_ctl_t                 r0_ctl;
	logic [2:0][SUM_W-1:0]    r0_sum;
	logic [7:0]               r0_mat;
	kind_t                    end_kind;

	assign pend = pend_q;

	always_comb begin
		phase_n     = phase_q;
		cnt_n       = cnt_q;
		name_n      = name_q;
		asm_n       = asm_q;
		skip_n      = skip_q;
		gv_n        = gv_q;
		lc_n        = lc_q;
		stopped_n   = stopped_q;
		pend_n      = 1'b0;
		pend_kind_n = KIND_OK;
		r0_ctl      = '{valid: 1'b0, kind: KIND_VOXEL, last_of_run: 1'b1};
		r0_sum      = '0;
		r0_mat      = '0;
		end_kind    = KIND_OK;
		cnt_inc     = cnt_q + 5'd1;
		full_word   = {byte_value, asm_q};
		lc_z_inc    = {1'b0, lc_q[2]} + {{DIM_W{1'b0}}, 1'b1};
		lc_y_inc    = {1'b0, lc_q[1]} + {{DIM_W{1'b0}}, 1'b1};
		lc_x_inc    = {1'b0, lc_q[0]} + {{DIM_W{1'b0}}, 1'b1};

		if (!stopped_q) begin
			unique case (phase_q)
				PH_HDR: begin
					cnt_n = cnt_inc;
					if (!cnt_q[2]) begin
						name_n = name_q | (32'(byte_value) << {cnt_q[1:0], 3'b000});
					end else if (cnt_q[1:0] != 2'd3) begin
						asm_n = asm_q | (24'(byte_value) << {cnt_q[1:0], 3'b000});
					end
					if (cnt_q == 5'd7) begin
						cnt_n  = '0;
						name_n = '0;
						asm_n  = '0;
						if (name_q == FDTD_NAME) begin
							phase_n = PH_VAL;
						end else if (!name_alnum(name_q)) begin
							r0_ctl.valid = 1'b1;
							r0_ctl.kind  = KIND_OK;
							stopped_n    = 1'b1;
						end else if (full_word[31]) begin
							r0_ctl.valid = 1'b1;
							r0_ctl.kind  = KIND_FAULT;
							stopped_n    = 1'b1;
						end else if (full_word[30:0] != 31'd0) begin
							skip_n  = full_word[30:0];
							phase_n = PH_SKIP;
						end
					end
				end
				PH_VAL: begin
					cnt_n = cnt_inc;
					if (cnt_q[1:0] != 2'd3) begin
						asm_n = asm_q | (24'(byte_value) << {cnt_q[1:0], 3'b000});
					end else begin
						asm_n = '0;
						if (full_word > 32'(MAX_DIM)) begin
							r0_ctl.valid = 1'b1;
							r0_ctl.kind  = KIND_FAULT;
							stopped_n    = 1'b1;
						end else begin
							for (int i = 0; i < 6; i++) begin
								if (cnt_q[4:2] == 3'(i)) begin
									gv_n[i] = full_word[DIM_W-1:0];
								end
							end
							if (cnt_q[4:2] == 3'd5) begin
								cnt_n        = '0;
								r0_ctl.valid = 1'b1;
								r0_ctl.kind  = KIND_GRID;
								r0_sum[0]    = SUM_W'(gv_q[0]) + SUM_W'(gv_q[3]);
								r0_sum[1]    = SUM_W'(gv_q[1]) + SUM_W'(gv_q[4]);
								r0_sum[2]    = SUM_W'(gv_q[2]) +
									SUM_W'(full_word[DIM_W-1:0]);
								lc_n         = '0;
								if (gv_q[0] == '0 || gv_q[1] == '0 || gv_q[2] == '0) begin
									phase_n = PH_HDR;
								end else begin
									phase_n = PH_PAY;
								end
							end
						end
					end
				end
				PH_PAY: begin
					r0_ctl.valid = 1'b1;
					r0_ctl.kind  = KIND_VOXEL;
					r0_sum[0]    = SUM_W'(lc_q[0]) + SUM_W'(gv_q[3]);
					r0_sum[1]    = SUM_W'(lc_q[1]) + SUM_W'(gv_q[4]);
					r0_sum[2]    = SUM_W'(lc_q[2]) + SUM_W'(gv_q[5]);
					r0_mat       = byte_value;
					// z runs fastest, then y, then x.
					lc_n[2] = lc_z_inc[DIM_W-1:0];
					if (lc_z_inc == {1'b0, gv_q[2]}) begin
						lc_n[2] = '0;
						lc_n[1] = lc_y_inc[DIM_W-1:0];
						if (lc_y_inc == {1'b0, gv_q[1]}) begin
							lc_n[1] = '0;
							lc_n[0] = lc_x_inc[DIM_W-1:0];
							if (lc_x_inc == {1'b0, gv_q[0]}) begin
								lc_n[0] = '0;
								phase_n = PH_HDR;
								cnt_n   = '0;
							end
						end
					end
				end
				PH_SKIP: begin
					if (skip_q != 31'd0) begin
						skip_n = skip_q - 31'd1;
					end
					if (skip_n == 31'd0) begin
						phase_n = PH_HDR;
					end
				end
				default: begin
					phase_n = PH_HDR;
				end
			endcase

			// End of file is judged on the state left after this byte.
			if (is_last && !stopped_n) begin
				stopped_n = 1'b1;
				if ((phase_n == PH_HDR && cnt_n == 5'd0) || phase_n == PH_SKIP) begin
					end_kind = KIND_OK;
				end else begin
					end_kind = KIND_FAULT;
				end
				if (r0_ctl.valid) begin
					r0_ctl.last_of_run = 1'b0;
					pend_n             = 1'b1;
					pend_kind_n        = end_kind;
				end else begin
					r0_ctl.valid = 1'b1;
					r0_ctl.kind  = end_kind;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			cnt_q       <= '0;
			name_q      <= '0;
			asm_q       <= '0;
			skip_q      <= '0;
			gv_q        <= '0;
			lc_q        <= '0;
			stopped_q   <= 1'b0;
			pend_q      <= 1'b0;
			pend_kind_q <= KIND_OK;
			ctl_s1      <= '{valid: 1'b0, kind: KIND_VOXEL, last_of_run: 1'b0};
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				cnt_q       <= cnt_n;
				name_q      <= name_n;
				asm_q       <= asm_n;
				skip_q      <= skip_n;
				gv_q        <= gv_n;
				lc_q        <= lc_n;
				stopped_q   <= stopped_n;
				pend_q      <= pend_n;
				pend_kind_q <= pend_kind_n;
			end else if (adv) begin
				pend_q <= 1'b0;
			end
			if (adv) begin
				if (accept) begin
					ctl_s1 <= r0_ctl;
				end else if (pend_q) begin
					ctl_s1 <= '{valid: 1'b1, kind: pend_kind_q, last_of_run: 1'b1};
				end else begin
					ctl_s1.valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (accept) begin
				sum_s1 <= r0_sum;
				mat_s1 <= r0_mat;
			end else begin
				sum_s1 <= '0;
				mat_s1 <= '0;
			end
		end
	end

endmodule

FILE: rtl/rvcp_round.sv
module rvcp_round #(
	parameter int unsigned MAX_DIM    = 4095,
	parameter int unsigned ROUND_UNIT = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  rvcp_pkg::res_ctl_t                   ctl_s1,
	input  logic [2:0][$clog2(MAX_DIM + 1):0]    sum_s1,
	input  logic [7:0]                           mat_s1,
	rvcp_res_if.source                           result_ch
);
	import rvcp_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int SUM_W = DIM_W + 1;
	localparam int RB    = $clog2(ROUND_UNIT + 1);
	localparam int N     = SUM_W + RB;
	localparam int SH    = N + RB;
	localparam int PW    = N + SH + 1;
	localparam int NR    = N + RB;
	// Reciprocal of the rounding unit; exact for every dividend below 2**N.
	localparam logic [SH:0] MUL =
		(SH + 1)'(((64'd1 << SH) + 64'(ROUND_UNIT) - 64'd1) / 64'(ROUND_UNIT));

	res_ctl_t                ctl_s2, ctl_s3;
	logic [2:0][N-1:0]       val_n, val_s2;
	logic [2:0][PW-1:0]      prod;
	logic [2:0][N-1:0]       ext;
	logic [2:0][NR-1:0]      scaled;
	logic [2:0][COORD_W-1:0] coord_n, coord_s3;
	logic [7:0]              mat_s2, mat_s3;

	// Stage 2: quotient of the rounded-up division for grid results.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext[a]   = N'(sum_s1[a]);
			prod[a]  = PW'(ext[a] + N'(ROUND_UNIT - 1)) * PW'(MUL);
			val_n[a] = (ctl_s1.kind == KIND_GRID) ? prod[a][SH +: N] : ext[a];
		end
	end

	// Stage 3: scale grid quotients back up to a multiple of the unit.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			scaled[a]  = NR'(val_s2[a]) * NR'(ROUND_UNIT);
			coord_n[a] = (ctl_s2.kind == KIND_GRID) ? COORD_W'(scaled[a]) :
				COORD_W'(val_s2[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, kind: KIND_VOXEL, last_of_run: 1'b0};
			ctl_s3 <= '{valid: 1'b0, kind: KIND_VOXEL, last_of_run: 1'b0};
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s2   <= val_n;
			mat_s2   <= mat_s1;
			coord_s3 <= coord_n;
			mat_s3   <= mat_s2;
		end
	end

	assign result_ch.valid       = ctl_s3.valid;
	assign result_ch.kind        = ctl_s3.kind;
	assign result_ch.last_of_run = ctl_s3.last_of_run;
	assign result_ch.coord_x     = coord_s3[0];
	assign result_ch.coord_y     = coord_s3[1];
	assign result_ch.coord_z     = coord_s3[2];
	assign result_ch.material    = mat_s3;

endmodule

FILE: rtl/riff_voxel_chunk_parser.sv
// Channel     Modport  Carries
// byte_ch     sink     byte_value, is_last
// result_ch   source   kind, coord_x, coord_y, coord_z, material, last_of_run
//
// One byte is taken per cycle unless the output stalls; its results leave through
// the s1, s2 and s3 registers. A final byte that also yields a voxel write or a
// grid size holds the input off while its end result enters the output pipeline.
// A result that is not taken stalls the whole pipeline, input included.
// Reset is asynchronous and at once clears all state but the result data; no clearing pass.
`include "riff_voxel_chunk_parser_macros.svh"

module riff_voxel_chunk_parser #(
	parameter int unsigned MAX_DIM    = 4095,
	parameter int unsigned ROUND_UNIT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	rvcp_byte_if.sink     byte_ch,
	rvcp_res_if.source    result_ch
);
	import rvcp_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic                    adv;
	logic                    accept;
	logic                    pend;
	res_ctl_t                ctl_s1;
	logic [2:0][DIM_W:0]     sum_s1;
	logic [7:0]              mat_s1;

	assign adv           = !result_ch.valid || result_ch.ready;
	assign byte_ch.ready = adv && !pend;
	assign accept        = byte_ch.valid && byte_ch.ready;

	rvcp_parser #(
		.MAX_DIM(MAX_DIM)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.adv       (adv),
		.byte_value(byte_ch.byte_value),
		.is_last   (byte_ch.is_last),
		.pend      (pend),
		.ctl_s1    (ctl_s1),
		.sum_s1    (sum_s1),
		.mat_s1    (mat_s1)
	);

	rvcp_round #(
		.MAX_DIM   (MAX_DIM),
		.ROUND_UNIT(ROUND_UNIT)
	) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.sum_s1   (sum_s1),
		.mat_s1   (mat_s1),
		.result_ch(result_ch)
	);

	// An end result always closes the run of its byte.
	`RVCP_ASSERT(a_end_is_last, clk, arst_n, result_ch.valid && (result_ch.kind == KIND_OK || result_ch.kind == KIND_FAULT), result_ch.last_of_run)
	// Nothing follows a delivered end result.
	`RVCP_ASSERT_NEXT(a_quiet_after_end, clk, arst_n, result_ch.valid && result_ch.ready && (result_ch.kind == KIND_OK || result_ch.kind == KIND_FAULT), !result_ch.valid)
	// A result that does not close its run is followed at once by the end result.
	`RVCP_ASSERT_NEXT(a_pair_adjacent, clk, arst_n, result_ch.valid && result_ch.ready && !result_ch.last_of_run, result_ch.valid && (result_ch.kind == KIND_OK || result_ch.kind == KIND_FAULT))

endmodule

FILE: dv/rvcp_parse_checker.sv
`timescale 1ns / 1ps

module rvcp_parse_checker
	import rvcp_pkg::*;
#(
	parameter int unsigned MAX_DIM    = 4095,
	parameter int unsigned ROUND_UNIT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	rvcp_byte_if        byte_ch,
	rvcp_res_if         result_ch,
	output int unsigned mismatches,
	output int unsigned expected_left
);

	typedef enum logic [1:0] {
		STAGE_HEADER,
		STAGE_VALUES,
		STAGE_PAYLOAD,
		STAGE_SKIP
	} parse_stage_t;

	typedef struct packed {
		kind_t              kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [7:0]         material;
		logic               last_of_run;
	} parse_result_t;

	parse_result_t expected_results[$];

	parse_stage_t stage;
	int unsigned  byte_pos;
	logic [31:0]  name_word;
	logic [31:0]  size_word;
	logic [31:0]  skip_left;
	logic [31:0]  dims[6];
	logic [31:0]  pos_x, pos_y, pos_z;
	logic         halted;

	function automatic parse_result_t make_result(input kind_t k, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z, input logic [7:0] m);
		parse_result_t r;
		r.kind        = k;
		r.x           = x[COORD_W-1:0];
		r.y           = y[COORD_W-1:0];
		r.z           = z[COORD_W-1:0];
		r.material    = m;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] round_to_unit(input logic [31:0] v);
		return ((v + ROUND_UNIT - 1) / ROUND_UNIT) * ROUND_UNIT;
	endfunction

	// Digits, upper case and lower case letters only.
	function automatic logic name_is_alnum(input logic [31:0] nm);
		logic [7:0] c;
		logic       ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			c = nm[8*k +: 8];
			if (!((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A)))
				ok = 1'b0;
		end
		return ok;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [31:0] word;
		int unsigned idx;
		int unsigned n_queued;
		logic        at_boundary;
		n_queued = expected_results.size();
		if (halted)
			return;
		case (stage)
			STAGE_HEADER: begin
				if (byte_pos < 4)
					name_word[8*byte_pos +: 8] = b;
				else
					size_word[8*(byte_pos-4) +: 8] = b;
				byte_pos++;
				if (byte_pos == 8) begin
					byte_pos = 0;
					if (name_word == FDTD_NAME) begin
						stage = STAGE_VALUES;
					end else if (!name_is_alnum(name_word)) begin
						expected_results.push_back(make_result(KIND_OK, 0, 0, 0, 0));
						halted = 1'b1;
					end else if (size_word[31]) begin
						expected_results.push_back(make_result(KIND_FAULT, 0, 0, 0, 0));
						halted = 1'b1;
					end else if (size_word != 0) begin
						skip_left = size_word;
						stage     = STAGE_SKIP;
					end
					name_word = '0;
					size_word = '0;
				end
			end
			STAGE_VALUES: begin
				size_word[8*(byte_pos%4) +: 8] = b;
				byte_pos++;
				if (byte_pos % 4 == 0) begin
					word      = size_word;
					size_word = '0;
					idx       = byte_pos / 4 - 1;
					if (word[31] || word > MAX_DIM || idx >= 6) begin
						expected_results.push_back(make_result(KIND_FAULT, 0, 0, 0, 0));
						halted = 1'b1;
					end else begin
						dims[idx] = word;
						if (idx == 5) begin
							byte_pos = 0;
							expected_results.push_back(make_result(KIND_GRID,
								round_to_unit(dims[0] + dims[3]),
								round_to_unit(dims[1] + dims[4]),
								round_to_unit(dims[2] + dims[5]), 0));
							pos_x = 0;
							pos_y = 0;
							pos_z = 0;
							// An empty grid takes no payload at all.
							if (dims[0] == 0 || dims[1] == 0 || dims[2] == 0)
								stage = STAGE_HEADER;
							else
								stage = STAGE_PAYLOAD;
						end
					end
				end
			end
			STAGE_PAYLOAD: begin
				expected_results.push_back(make_result(KIND_VOXEL, pos_x + dims[3],
					pos_y + dims[4], dims[5] + pos_z, b));
				pos_z++;
				if (pos_z >= dims[2]) begin
					pos_z = 0;
					pos_y++;
					if (pos_y >= dims[1]) begin
						pos_y = 0;
						pos_x++;
						if (pos_x >= dims[0]) begin
							pos_x    = 0;
							stage    = STAGE_HEADER;
							byte_pos = 0;
						end
					end
				end
			end
			default: begin
				if (skip_left > 0)
					skip_left--;
				if (skip_left == 0)
					stage = STAGE_HEADER;
			end
		endcase

		if (last && !halted) begin
			// A skip that runs past the end of the file still counts as clean.
			at_boundary = (stage == STAGE_HEADER && byte_pos == 0) || stage == STAGE_SKIP;
			expected_results.push_back(make_result(at_boundary ? KIND_OK : KIND_FAULT,
				0, 0, 0, 0));
			halted = 1'b1;
		end

		if (expected_results.size() > n_queued)
			expected_results[$].last_of_run = 1'b1;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_result_t want;
		if (!arst_n) begin
			stage     = STAGE_HEADER;
			byte_pos  = 0;
			name_word = '0;
			size_word = '0;
			skip_left = '0;
			foreach (dims[k])
				dims[k] = '0;
			pos_x      = '0;
			pos_y      = '0;
			pos_z      = '0;
			halted     = 1'b0;
			mismatches = 0;
			expected_results.delete();
			expected_left <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				parse_byte(byte_ch.byte_value, byte_ch.is_last);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d", result_ch.kind);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(result_ch.kind));
					check_field("coord_x", 32'(want.x), 32'(result_ch.coord_x));
					check_field("coord_y", 32'(want.y), 32'(result_ch.coord_y));
					check_field("coord_z", 32'(want.z), 32'(result_ch.coord_z));
					check_field("material", 32'(want.material), 32'(result_ch.material));
					check_field("last_of_run", 32'(want.last_of_run),
						32'(result_ch.last_of_run));
				end
			end
			expected_left <= expected_results.size();
		end
	end

endmodule

FILE: dv/tb_riff_voxel_chunk_parser.sv
`timescale 1ns / 1ps

module tb_riff_voxel_chunk_parser;
	import rvcp_pkg::*;

	localparam int unsigned MAX_DIM    = 4095;
	localparam int unsigned ROUND_UNIT = 4;
	localparam int unsigned FILE_BYTES = 1350;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} riff_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned expected_left;

	riff_byte_t riff_stream[$];

	rvcp_byte_if byte_ch ();
	rvcp_res_if  result_ch ();

	riff_voxel_chunk_parser #(
		.MAX_DIM   (MAX_DIM),
		.ROUND_UNIT(ROUND_UNIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.result_ch(result_ch)
	);

	rvcp_parse_checker #(
		.MAX_DIM   (MAX_DIM),
		.ROUND_UNIT(ROUND_UNIT)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_ch      (byte_ch),
		.result_ch    (result_ch),
		.mismatches   (mismatches),
		.expected_left(expected_left)
	);

	always #1 clk = ~clk;

	task automatic put_byte(input logic [7:0] b);
		riff_stream.push_back('{value: b, last: 1'b0});
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			put_byte(w[8*k +: 8]);
	endtask

	task automatic put_header(input logic [31:0] name, input logic [31:0] size);
		put_word(name);
		put_word(size);
	endtask

	function automatic logic [31:0] random_name();
		logic [31:0] nm;
		int unsigned r;
		do begin
			for (int k = 0; k < 4; k++) begin
				r = $urandom_range(0, 61);
				if (r < 10)
					nm[8*k +: 8] = 8'h30 + 8'(r);
				else if (r < 36)
					nm[8*k +: 8] = 8'h41 + 8'(r - 10);
				else
					nm[8*k +: 8] = 8'h61 + 8'(r - 36);
			end
		end while (nm == FDTD_NAME);
		return nm;
	endfunction

	task automatic put_skip_chunk(input logic [31:0] name, input int unsigned size);
		put_header(name, size);
		repeat (size)
			put_byte(8'($urandom_range(0, 255)));
	endtask

	// The header size of an fdtd chunk is ignored, so it is random here.
	task automatic put_fdtd(input int unsigned sx, input int unsigned sy, input int unsigned sz,
		input int unsigned ox, input int unsigned oy, input int unsigned oz,
		input int unsigned payload_len);
		put_header(FDTD_NAME, $urandom());
		put_word(sx);
		put_word(sy);
		put_word(sz);
		put_word(ox);
		put_word(oy);
		put_word(oz);
		repeat (payload_len)
			put_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic int unsigned random_offset();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, MAX_DIM);
		return $urandom_range(0, 20);
	endfunction

	initial begin : stimulus
		int unsigned sx, sy, sz, n, r, gap, pause_at, big_grids;
		logic [31:0] name;
		logic [7:0]  c;

		arst_n                = 1'b0;
		byte_ch.valid         = 1'b0;
		byte_ch.byte_value    = 8'h00;
		byte_ch.is_last       = 1'b0;
		big_grids             = 0;

		// Directed: empty skip, short skip with the alphabet edges in its name, the widest
		// grid, byte extremes as payload and a z/y/x wrap.
		put_skip_chunk({8'h39, 8'h30, 8'h5A, 8'h41}, 0);
		put_skip_chunk({8'h7A, 8'h61, 8'h39, 8'h30}, 3);
		put_fdtd(MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, MAX_DIM, 0);
		put_header(FDTD_NAME, 32'hFFFF_FFFF);
		put_word(1);
		put_word(1);
		put_word(2);
		put_word(0);
		put_word(0);
		put_word(0);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_fdtd(2, 2, 2, 3, 5, 7, 8);

		while (riff_stream.size() < FILE_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 2 && big_grids < 2) begin
				big_grids++;
				put_fdtd(6, 6, 6, random_offset(), random_offset(), random_offset(), 216);
			end else if (r < 65) begin
				sx = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
				sy = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
				sz = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
				put_fdtd(sx, sy, sz, random_offset(), random_offset(), random_offset(),
					sx * sy * sz);
			end else if (r < 90) begin
				put_skip_chunk(random_name(), $urandom_range(0, 16));
			end else begin
				// A skipped chunk whose body looks like an fdtd header.
				put_header(random_name(), 8);
				put_word(FDTD_NAME);
				put_word($urandom());
			end
		end

		case ($urandom_range(0, 9))
			0: begin
				put_fdtd(2, 1, 3, random_offset(), random_offset(), random_offset(), 6);
				riff_stream[$].last = 1'b1;
			end
			1: begin
				put_header(random_name(), 0);
				riff_stream[$].last = 1'b1;
			end
			2: begin
				put_header(random_name(), $urandom_range(20, 100));
				repeat ($urandom_range(1, 8))
					put_byte(8'($urandom_range(0, 255)));
				riff_stream[$].last = 1'b1;
			end
			3: begin
				repeat ($urandom_range(1, 7))
					put_byte(8'($urandom_range(0, 255)));
				riff_stream[$].last = 1'b1;
			end
			4: begin
				put_header(FDTD_NAME, $urandom());
				n = $urandom_range(1, 23);
				for (int k = 0; k < n; k++)
					put_byte((k % 4 == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
				riff_stream[$].last = 1'b1;
			end
			5: begin
				put_fdtd(2, 2, 2, random_offset(), random_offset(), random_offset(),
					$urandom_range(1, 7));
				riff_stream[$].last = 1'b1;
			end
			6: begin
				name = random_name();
				do
					c = 8'($urandom_range(0, 255));
				while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
					(c >= 8'h61 && c <= 8'h7A));
				name[8*$urandom_range(0, 3) +: 8] = c;
				put_header(name, $urandom());
			end
			7: put_header(random_name(), $urandom() | 32'h8000_0000);
			8: begin
				put_header(FDTD_NAME, $urandom());
				repeat ($urandom_range(0, 5))
					put_word($urandom_range(0, MAX_DIM));
				if ($urandom_range(0, 1))
					put_word($urandom() | 32'h8000_0000);
				else
					put_word($urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF));
			end
			default: begin
				put_fdtd($urandom_range(1, 9), 0, $urandom_range(0, 9), random_offset(),
					random_offset(), random_offset(), 0);
				riff_stream[$].last = 1'b1;
			end
		endcase
		// Bytes after the end are taken and dropped.
		repeat ($urandom_range(2, 6)) begin
			put_byte(8'($urandom_range(0, 255)));
			riff_stream[$].last = 1'($urandom_range(0, 1));
		end
		pause_at = riff_stream.size() / 2;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (riff_stream[i]) begin
			if (i == pause_at) begin
				// Hold off new requests until every expected result has drained.
				byte_ch.valid <= 1'b0;
				do @(posedge clk); while (expected_left != 0);
			end
			r = $urandom_range(0, 99);
			if (i % 256 < 40 || r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 60);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_ch.valid      <= 1'b1;
			byte_ch.byte_value <= riff_stream[i].value;
			byte_ch.is_last    <= riff_stream[i].last;
			do @(posedge clk); while (!byte_ch.ready);
		end
		byte_ch.valid <= 1'b0;

		do @(posedge clk); while (expected_left != 0);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("[riff_voxel_chunk_parser] OK");
		else
			$display("[riff_voxel_chunk_parser] ERROR");
		$finish;
	end

	initial begin : result_backpressure
		int unsigned r;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(posedge clk);
			end else if (r < 55) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 95) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#1_600_000;
		$display("[riff_voxel_chunk_parser] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rvcp_pkg.sv
rtl/rvcp_ifs.sv
rtl/rvcp_parser.sv
rtl/rvcp_round.sv
rtl/riff_voxel_chunk_parser.sv
dv/rvcp_parse_checker.sv
dv/tb_riff_voxel_chunk_parser.sv
